FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: hw/rtl/fsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg: FASTA record parser shared types
// Transaction structs, result kinds, error codes, parser phases and the
// character classes used by the front end.
// ----------------------------------------------------------------------------
package fsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [31:0] record_length;
    } out_item_t;

    // Result kinds
    localparam logic [2:0] KIND_NAME  = 3'd0;
    localparam logic [2:0] KIND_DESC  = 3'd1;
    localparam logic [2:0] KIND_BASE  = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // Error codes
    localparam logic [7:0] ERR_BAD_START  = 8'd0;
    localparam logic [7:0] ERR_EOF_NAME   = 8'd1;
    localparam logic [7:0] ERR_EOF_DESC   = 8'd2;
    localparam logic [7:0] ERR_BAD_BASE   = 8'd3;
    localparam logic [7:0] ERR_EMPTY_NAME = 8'd4;
    localparam logic [7:0] ERR_EMPTY_SEQ  = 8'd5;

    // Characters
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [5:0] {
        PH_BETWEEN   = 6'b000001,
        PH_NAME      = 6'b000010,
        PH_DESC_SKIP = 6'b000100,
        PH_DESC      = 6'b001000,
        PH_SEQ       = 6'b010000,
        PH_ERROR     = 6'b100000
    } phase_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR) || (c == CH_TAB) || (c == CH_SPACE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_TAB) || (c == CH_SPACE);
    endfunction

    // IUPAC nucleotide letter, either case
    function automatic logic is_iupac(input logic [7:0] c);
        logic [7:0] lc;
        logic       ok;
        lc = ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? (c | CASE_BIT) : c;
        case (lc) inside
            "a", "c", "g", "t", "u", "n", "r", "y", "k",
            "m", "s", "w", "b", "d", "h", "v", "x": ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

FILE: hw/rtl/fsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_front: FASTA parser front end
// Classifies each accepted byte against the record phase and forms at most
// one result per byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsp_front #(
    parameter int LENGTH_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  fsp_pkg::in_item_t  item,
    output logic               res_valid,
    output fsp_pkg::out_item_t res
);

    fsp_pkg::phase_t        phase_reg, phase_next;
    logic                   name_nonempty_reg, name_nonempty_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [31:0]            len_sat;
    logic [7:0]             c;
    logic                   eof;

    assign c   = item.data_byte;
    assign eof = item.end_of_input;

    // Clamp the running count to the 32-bit result field
    generate
        if (LENGTH_BITS > 32) begin : g_wide
            assign len_sat = (|count_reg[LENGTH_BITS-1:32]) ? '1 : count_reg[31:0];
        end
        else if (LENGTH_BITS == 32) begin : g_exact
            assign len_sat = count_reg;
        end
        else begin : g_narrow
            assign len_sat = {{(32-LENGTH_BITS){1'b0}}, count_reg};
        end
    endgenerate

    always_comb
    begin
        phase_next         = phase_reg;
        name_nonempty_next = name_nonempty_reg;
        count_next         = count_reg;
        res_valid          = 1'b0;
        res                = '0;
        if (accept)
        begin
            unique case (phase_reg)
                fsp_pkg::PH_BETWEEN:
                begin
                    if (!eof && !fsp_pkg::is_space(c))
                    begin
                        if (c != fsp_pkg::CH_GT)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = fsp_pkg::KIND_ERROR;
                            res.value  = fsp_pkg::ERR_BAD_START;
                            phase_next = fsp_pkg::PH_ERROR;
                        end
                        else
                        begin
                            phase_next         = fsp_pkg::PH_NAME;
                            name_nonempty_next = 1'b0;
                            count_next         = '0;
                        end
                    end
                end
                fsp_pkg::PH_NAME:
                begin
                    if (eof)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = fsp_pkg::KIND_ERROR;
                        res.value  = fsp_pkg::ERR_EOF_NAME;
                        phase_next = fsp_pkg::PH_ERROR;
                    end
                    else if (fsp_pkg::is_space(c))
                    begin
                        phase_next = (c == fsp_pkg::CH_LF) ? fsp_pkg::PH_SEQ
                                                           : fsp_pkg::PH_DESC_SKIP;
                    end
                    else
                    begin
                        name_nonempty_next = 1'b1;
                        res_valid          = 1'b1;
                        res.kind           = fsp_pkg::KIND_NAME;
                        res.value          = c;
                    end
                end
                fsp_pkg::PH_DESC_SKIP, fsp_pkg::PH_DESC:
                begin
                    if (eof)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = fsp_pkg::KIND_ERROR;
                        res.value  = fsp_pkg::ERR_EOF_DESC;
                        phase_next = fsp_pkg::PH_ERROR;
                    end
                    else if (c == fsp_pkg::CH_LF)
                    begin
                        phase_next = fsp_pkg::PH_SEQ;
                    end
                    else if (!((phase_reg == fsp_pkg::PH_DESC_SKIP) && fsp_pkg::is_blank(c)))
                    begin
                        phase_next = fsp_pkg::PH_DESC;
                        res_valid  = 1'b1;
                        res.kind   = fsp_pkg::KIND_DESC;
                        res.value  = c;
                    end
                end
                fsp_pkg::PH_SEQ:
                begin
                    if (eof || (!fsp_pkg::is_space(c) && (c == fsp_pkg::CH_GT)))
                    begin
                        // Close the record
                        res_valid = 1'b1;
                        if (!name_nonempty_reg)
                        begin
                            res.kind   = fsp_pkg::KIND_ERROR;
                            res.value  = fsp_pkg::ERR_EMPTY_NAME;
                            phase_next = fsp_pkg::PH_ERROR;
                        end
                        else if (count_reg == '0)
                        begin
                            res.kind   = fsp_pkg::KIND_ERROR;
                            res.value  = fsp_pkg::ERR_EMPTY_SEQ;
                            phase_next = fsp_pkg::PH_ERROR;
                        end
                        else
                        begin
                            res.kind           = fsp_pkg::KIND_END;
                            res.record_length  = len_sat;
                            phase_next         = eof ? fsp_pkg::PH_BETWEEN : fsp_pkg::PH_NAME;
                            name_nonempty_next = 1'b0;
                            count_next         = '0;
                        end
                    end
                    else if (!fsp_pkg::is_space(c))
                    begin
                        res_valid = 1'b1;
                        if (!fsp_pkg::is_iupac(c))
                        begin
                            res.kind   = fsp_pkg::KIND_ERROR;
                            res.value  = fsp_pkg::ERR_BAD_BASE;
                            phase_next = fsp_pkg::PH_ERROR;
                        end
                        else
                        begin
                            res.kind  = fsp_pkg::KIND_BASE;
                            res.value = c;
                            if (count_reg != '1)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                end
                fsp_pkg::PH_ERROR:
                begin
                    phase_next = fsp_pkg::PH_ERROR;
                end
                default:
                begin
                    phase_next = fsp_pkg::PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= fsp_pkg::PH_BETWEEN;
            name_nonempty_reg <= 1'b0;
            count_reg         <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            name_nonempty_reg <= name_nonempty_next;
            count_reg         <= count_next;
        end
    end

    `ASSERT_CLK(a_error_holds,
        (phase_reg == fsp_pkg::PH_ERROR) |=> (phase_reg == fsp_pkg::PH_ERROR),
        "error phase left before reset")
    `ASSERT_CLK(a_error_enters,
        (res_valid && (res.kind == fsp_pkg::KIND_ERROR)) |=> (phase_reg == fsp_pkg::PH_ERROR),
        "error reported without entering error phase")
    `ASSERT_NEVER(a_no_result_in_error,
        res_valid && (phase_reg == fsp_pkg::PH_ERROR),
        "result produced after an error")

endmodule

FILE: hw/rtl/fsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_queue: result queue
// Small register queue between the parser front end and the result port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsp_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  fsp_pkg::out_item_t wr_data,
    input  logic               rd_en,
    output fsp_pkg::out_item_t rd_data,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fsp_pkg::out_item_t store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_FULL);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_CLK(a_count_bound, count_reg <= CNT_FULL, "queue count beyond depth")
    `ASSERT_CLK(a_count_up, (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1), "queue count missed a write")

endmodule

FILE: hw/rtl/fasta_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_record_parser: byte-serial FASTA record parser
// Splits a FASTA text stream into name, description and sequence bytes,
// checks bases against the IUPAC letters and reports record ends and errors.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake      Payload
//  -------  -------------  -------------------------------------------
//  input    push / full    item   : data_byte, end_of_input
//  result   pop / empty    result : kind, value, record_length
//
// One input transaction is taken per cycle while the queue is not full;
// the front end classifies it in the accepting cycle and writes any result
// into the result queue, which shows it from the cycle after its input
// unless older results wait ahead. full rises only when QUEUE_DEPTH results
// wait unread; pop frees a slot that push may use from the next cycle on.
// Reset (rst_n low) returns the parser to the between-records phase and
// empties the queue; an error holds the parser silent until reset.
// ----------------------------------------------------------------------------

module fasta_record_parser #(
    parameter int LENGTH_BITS = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  fsp_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output fsp_pkg::out_item_t result
);

    logic               accept;
    logic               res_valid;
    fsp_pkg::out_item_t res;

    // Accept an input transaction whenever the queue has room
    assign accept = push && !full;

    // Front end: phase tracking and byte classification
    fsp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Back end: hold results until the consumer pops them
    fsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty),
        .full    (full)
    );

endmodule

FILE: bench/fasta_record_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_record_parser_test: self-checking bench for the FASTA record parser
// Streams FASTA text through the input port, predicts every name,
// description, base, record-end and error transaction in a behavioural
// parser kept here, and compares each popped result field by field.
// ----------------------------------------------------------------------------
module fasta_record_parser_test;

    // Results reach the result queue in the cycle after their input; allow a margin on top.
    localparam int SETTLE_CYCLES = 8;
    // Watchdog limit, far beyond the slowest correct run.
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int ROUND_ITEMS   = 100;

    logic               clk    = 1'b0;
    logic               rst_n  = 1'b0;
    logic               push   = 1'b0;
    logic               pop    = 1'b0;
    fsp_pkg::in_item_t  item   = '0;
    logic               full;
    logic               empty;
    fsp_pkg::out_item_t result;

    // Idle percentages for each side, changed between rounds.
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    // Parser state as this bench sees it.
    fsp_pkg::phase_t ph         = fsp_pkg::PH_BETWEEN;
    logic            name_seen  = 1'b0;
    logic [31:0]     base_count = '0;

    // Results that the stream so far must still produce, oldest first.
    fsp_pkg::out_item_t tokens_due[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int records_closed = 0;
    int bases_parsed   = 0;
    int error_seen     = -1;

    // The 17 IUPAC letters in both cases.
    string base_letters = "ACGTUNRYKMSWBDHVXacgtunrykmswbdhvx";

    fasta_record_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------------
    function automatic logic is_white(input logic [7:0] c);
        return c == fsp_pkg::CH_LF || c == fsp_pkg::CH_CR || c == fsp_pkg::CH_TAB ||
               c == fsp_pkg::CH_SPACE;
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        for (int i = 0; i < base_letters.len(); i++)
            if (base_letters[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Behavioural parser: advance the state by one byte and queue whatever
    // transaction that byte must produce.
    // ------------------------------------------------------------------------
    function automatic void queue_token(input logic [2:0] kind, input logic [7:0] value,
                                        input logic [31:0] length);
        fsp_pkg::out_item_t t;
        t.kind          = kind;
        t.value         = value;
        t.record_length = length;
        tokens_due.push_back(t);
    endfunction

    function automatic void raise_error(input logic [7:0] code);
        ph         = fsp_pkg::PH_ERROR;
        error_seen = code;
        queue_token(fsp_pkg::KIND_ERROR, code, '0);
    endfunction

    // A record closes only with a name and at least one base.
    function automatic void close_record(input fsp_pkg::phase_t next_ph);
        if (!name_seen)
            raise_error(fsp_pkg::ERR_EMPTY_NAME);
        else if (base_count == '0)
            raise_error(fsp_pkg::ERR_EMPTY_SEQ);
        else
        begin
            queue_token(fsp_pkg::KIND_END, '0, base_count);
            records_closed++;
            ph         = next_ph;
            name_seen  = 1'b0;
            base_count = '0;
        end
    endfunction

    function automatic void parse_char(input fsp_pkg::in_item_t it);
        logic [7:0] c;
        logic       eoi;
        c   = it.data_byte;
        eoi = it.end_of_input;
        case (ph)
            fsp_pkg::PH_BETWEEN:
                if (!(eoi || is_white(c)))
                begin
                    if (c != fsp_pkg::CH_GT)
                        raise_error(fsp_pkg::ERR_BAD_START);
                    else
                    begin
                        ph         = fsp_pkg::PH_NAME;
                        name_seen  = 1'b0;
                        base_count = '0;
                    end
                end
            fsp_pkg::PH_NAME:
                if (eoi)
                    raise_error(fsp_pkg::ERR_EOF_NAME);
                else if (is_white(c))
                    ph = (c == fsp_pkg::CH_LF) ? fsp_pkg::PH_SEQ : fsp_pkg::PH_DESC_SKIP;
                else
                begin
                    name_seen = 1'b1;
                    queue_token(fsp_pkg::KIND_NAME, c, '0);
                end
            fsp_pkg::PH_DESC_SKIP, fsp_pkg::PH_DESC:
                if (eoi)
                    raise_error(fsp_pkg::ERR_EOF_DESC);
                else if (c == fsp_pkg::CH_LF)
                    ph = fsp_pkg::PH_SEQ;
                else if (!(ph == fsp_pkg::PH_DESC_SKIP && c != fsp_pkg::CH_LF && is_white(c)))
                begin
                    ph = fsp_pkg::PH_DESC;
                    queue_token(fsp_pkg::KIND_DESC, c, '0);
                end
            fsp_pkg::PH_SEQ:
                if (eoi)
                    close_record(fsp_pkg::PH_BETWEEN);
                else if (is_white(c))
                    ;
                else if (c == fsp_pkg::CH_GT)
                    close_record(fsp_pkg::PH_NAME);
                else if (!is_base(c))
                    raise_error(fsp_pkg::ERR_BAD_BASE);
                else
                begin
                    // Saturate rather than wrap.
                    if (base_count != '1)
                        base_count++;
                    bases_parsed++;
                    queue_token(fsp_pkg::KIND_BASE, c, '0);
                end
            default:
                ph = fsp_pkg::PH_ERROR;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Entered and left at a falling edge with push still high,
    // so back-to-back transactions never lower and raise push in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input fsp_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        // Hold the transaction until a rising edge sees room in the queue.
        @(posedge clk);
        while (full)
            @(posedge clk);
        parse_char(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] c);
        fsp_pkg::in_item_t it;
        it.data_byte    = c;
        it.end_of_input = 1'b0;
        send_item(it);
    endtask

    // The data byte rides along at random: the parser must ignore it.
    task automatic send_eof();
        fsp_pkg::in_item_t it;
        it.data_byte    = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Stop sending and hold off until every predicted result has been popped,
    // then let the block settle in case its last input produced nothing.
    task automatic drain_results();
        push <= 1'b0;
        while (tokens_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: pop at random, and check every transaction taken.
    // ------------------------------------------------------------------------
    always @(negedge clk)
        pop <= ($urandom_range(0, 99) >= take_idle_pct);

    always @(posedge clk)
    begin
        fsp_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d length %0d",
                       result.kind, result.value, result.record_length);
                mismatch_count++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (result.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    mismatch_count++;
                end
                if (result.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, result.value);
                    mismatch_count++;
                end
                if (result.record_length !== want.record_length)
                begin
                    $error("record_length: expected %0d, got %0d",
                           want.record_length, result.record_length);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random byte sources
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_white();
        case ($urandom_range(0, 3))
            0:       return fsp_pkg::CH_LF;
            1:       return fsp_pkg::CH_CR;
            2:       return fsp_pkg::CH_TAB;
            default: return fsp_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return fsp_pkg::CH_CR;
            1:       return fsp_pkg::CH_TAB;
            default: return fsp_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_base();
        return base_letters[$urandom_range(0, base_letters.len() - 1)];
    endfunction

    // Any byte that is not whitespace, '>' included, can sit in a name.
    function automatic logic [7:0] pick_name_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_white(b));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // One well-formed record with random content and layout. The record is
    // left open unless it ends in an end-of-input mark; the next '>' closes it.
    // ------------------------------------------------------------------------
    task automatic send_record();
        int         name_len;
        int         desc_len;
        int         seq_len;
        logic [7:0] b;

        // Drop a little whitespace or a stray end-of-input mark in front.
        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(0, 3) == 0)
                send_eof();
            else
                send_char(pick_white());
        end
        send_char(fsp_pkg::CH_GT);

        name_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                               : $urandom_range(1, 8);
        repeat (name_len)
            send_char(pick_name_byte());

        if ($urandom_range(0, 2) == 0)
            send_char(fsp_pkg::CH_LF);   // no description at all
        else
        begin
            repeat ($urandom_range(1, 2))
                send_char(pick_blank());
            desc_len = $urandom_range(0, 8);
            repeat (desc_len)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == fsp_pkg::CH_LF);
                send_char(b);
            end
            send_char(fsp_pkg::CH_LF);
        end

        // Mostly short sequences, now and then a long one.
        seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 12);
        repeat (seq_len)
        begin
            if ($urandom_range(0, 99) < 15)
                send_char(pick_white());
            send_char(pick_base());
        end

        if ($urandom_range(0, 9) < 3)
            send_eof();
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Hand-written stream: whitespace before the first record, extreme name
    // bytes, blanks before the description, a blank inside it, whitespace in
    // the sequence, both letter cases, a '>' that closes one record and opens
    // the next, a name ended by LF, end of input closing a record and a
    // further end-of-input mark between records.
    task automatic test_directed_stream();
        send_char(fsp_pkg::CH_SPACE);
        send_char(fsp_pkg::CH_LF);
        send_char(fsp_pkg::CH_CR);
        send_char(fsp_pkg::CH_GT);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(fsp_pkg::CH_TAB);
        send_char(fsp_pkg::CH_SPACE);
        send_text("d");
        send_char(fsp_pkg::CH_SPACE);
        send_char(8'h80);
        send_char(fsp_pkg::CH_LF);
        send_text("ac");
        send_char(fsp_pkg::CH_CR);
        send_text("GT>z>");
        send_char(fsp_pkg::CH_LF);
        send_text("Xn");
        send_eof();
        send_eof();
        // Bytes after end of input open a fresh stream.
        send_text(">q");
        send_char(fsp_pkg::CH_LF);
        send_text("u");
        send_eof();
        drain_results();
    endtask

    // Random records under one idle pattern; pause for a full drain at the
    // end so the next round starts from an empty result queue.
    task automatic test_random_records(input int send_pct, input int take_pct);
        int target;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        target        = items_sent + ROUND_ITEMS;
        while (items_sent < target)
            send_record();
        send_eof();
        drain_results();
    endtask

    // Reset is applied once only, so each run provokes a single error,
    // chosen by the seed, and then checks that the parser stays silent.
    task automatic test_error_hold();
        logic [7:0] code;
        logic [7:0] b;
        code = 8'($urandom_range(0, 5));
        case (code)
            fsp_pkg::ERR_BAD_START:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (is_white(b) || b == fsp_pkg::CH_GT);
                send_char(b);
            end
            fsp_pkg::ERR_EOF_NAME:
            begin
                send_text(">a");
                send_eof();
            end
            fsp_pkg::ERR_EOF_DESC:
            begin
                send_text(">a");
                send_char(pick_blank());
                if ($urandom_range(0, 1) == 1)
                    send_text("d");
                send_eof();
            end
            fsp_pkg::ERR_BAD_BASE:
            begin
                send_text(">a");
                send_char(fsp_pkg::CH_LF);
                send_text("A");
                do
                    b = 8'($urandom_range(0, 255));
                while (is_white(b) || b == fsp_pkg::CH_GT || is_base(b));
                send_char(b);
            end
            fsp_pkg::ERR_EMPTY_NAME:
            begin
                send_char(fsp_pkg::CH_GT);
                if ($urandom_range(0, 1) == 1)
                    send_char(fsp_pkg::CH_SPACE);
                send_char(fsp_pkg::CH_LF);
                send_text("A");
                if ($urandom_range(0, 1) == 1)
                    send_eof();
                else
                    send_char(fsp_pkg::CH_GT);
            end
            default:
            begin
                send_text(">a");
                send_char(fsp_pkg::CH_LF);
                if ($urandom_range(0, 1) == 1)
                    send_eof();
                else
                    send_char(fsp_pkg::CH_GT);
            end
        endcase
        // Anything after the error must be swallowed.
        send_text(">b");
        send_char(fsp_pkg::CH_LF);
        send_text("ACGT");
        repeat (8)
        begin
            if ($urandom_range(0, 3) == 0)
                send_eof();
            else
                send_char(8'($urandom_range(0, 255)));
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_stream();
        test_random_records(9, 46);
        test_random_records(46, 9);
        test_random_records(0, 0);
        test_error_hold();

        if (tokens_due.size() != 0)
        begin
            $error("%0d results never arrived", tokens_due.size());
            mismatch_count++;
        end

        $display("Parsed %0d input bytes into %0d records holding %0d bases;",
                 items_sent, records_closed, bases_parsed);
        $display("error code %0d was provoked and held until the end.", error_seen);
        if (mismatch_count == 0)
            $display("fasta_record_parser_test OK");
        else
            $display("fasta_record_parser_test NOT OK");
        $finish;
    end

    // Watchdog: a stalled handshake ends the run here.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("fasta_record_parser_test NOT OK");
        $finish;
    end

endmodule
